@@ sv/mjdc_pkg.sv @@
// shared types, constants and tables for the mjd time stamp converter
// no dependencies; imported by mjdc_date and mjd_bcd_to_calendar_time
package mjdc_pkg;

    // pipeline depth from accepted beat to result strobe
    localparam int unsigned DATE_LAT = 8;

    // early date substitution
    localparam logic [15:0] MJD_FLOOR   = 16'd15078;
    localparam logic [15:0] MJD_DEFAULT = 16'd53371;

    // year term: (20*mjd - 301564) / 7305
    localparam logic [19:0] YEAR_BIAS  = 20'd301564;
    localparam logic [11:0] YEAR_RECIP = 12'd2296;      // floor(2^24 / 7305)
    localparam logic [20:0] YEAR_DIV   = 21'd7305;

    // weekday term: (mjd + 2) mod 7
    localparam logic [16:0] WEEK_OFFSET = 17'd2;
    localparam logic [16:0] WEEK_RECIP  = 17'd74898;    // floor(2^19 / 7)
    localparam logic [16:0] WEEK_DIV    = 17'd7;

    // year length term: 365*y + y/4
    localparam logic [16:0] YEAR_DAYS = 17'd365;

    // month term: 1000*v / 306001
    localparam logic [19:0] MONTH_BIAS  = 20'd149561;
    localparam logic [23:0] MONTH_RECIP = 24'd14035794; // floor(1000 * 2^32 / 306001)
    localparam logic [23:0] MONTH_DIV   = 24'd306001;
    localparam logic [23:0] MONTH_SCALE = 24'd1000;

    // day term: 14956 mod 256, only the low byte of the day is kept
    localparam logic [7:0]  DAY_BIAS8 = 8'd108;

    localparam logic [10:0] YEAR_BASE = 11'd1900;

    // converted calendar date for one beat
    typedef struct packed {
        logic [10:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
    } t_date;

    // days before month m: floor(m * 306001 / 10000)
    function automatic logic [8:0] month_day_offset(input logic [3:0] m);
        logic [8:0] q;
        case (m)
            4'd0:    q = 9'd0;
            4'd1:    q = 9'd30;
            4'd2:    q = 9'd61;
            4'd3:    q = 9'd91;
            4'd4:    q = 9'd122;
            4'd5:    q = 9'd153;
            4'd6:    q = 9'd183;
            4'd7:    q = 9'd214;
            4'd8:    q = 9'd244;
            4'd9:    q = 9'd275;
            4'd10:   q = 9'd306;
            4'd11:   q = 9'd336;
            4'd12:   q = 9'd367;
            4'd13:   q = 9'd397;
            4'd14:   q = 9'd428;
            4'd15:   q = 9'd459;
            default: q = 9'd0;
        endcase
        return q;
    endfunction

endpackage

@@ sv/mjdc_date.sv @@
// eight-stage pipeline turning a modified julian date into year, month, day, weekday
// depends on mjdc_pkg for constants, the month offset table and t_date
module mjdc_date import mjdc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [15:0] i_mjd,
    output logic        o_valid,
    output t_date       o_date
);

    // stage 1 inputs: early date substitution, year and weekday numerators
    logic [15:0] n_s1_mjd;
    logic [20:0] w_ny_full;
    logic [19:0] n_s1_ny;
    logic [16:0] n_s1_nw;

    always_comb begin
        n_s1_mjd  = (i_mjd <= MJD_FLOOR) ? MJD_DEFAULT : i_mjd;
        w_ny_full = {1'b0, n_s1_mjd, 4'b0} + {3'b0, n_s1_mjd, 2'b0} - {1'b0, YEAR_BIAS};
        n_s1_ny   = w_ny_full[19:0];
        n_s1_nw   = {1'b0, n_s1_mjd} + WEEK_OFFSET;
    end

    logic        r_s1_valid;
    logic [15:0] r_s1_mjd;
    logic [19:0] r_s1_ny;
    logic [16:0] r_s1_nw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
        end
        r_s1_mjd <= n_s1_mjd;
        r_s1_ny  <= n_s1_ny;
        r_s1_nw  <= n_s1_nw;
    end

    // stage 2: reciprocal estimates of the year and week quotients
    logic [31:0] w_y_prod;
    logic [33:0] w_w_prod;
    logic [7:0]  n_s2_yest;
    logic [13:0] n_s2_west;

    always_comb begin
        w_y_prod  = {12'b0, r_s1_ny} * {20'b0, YEAR_RECIP};
        w_w_prod  = {17'b0, r_s1_nw} * {17'b0, WEEK_RECIP};
        n_s2_yest = w_y_prod[31:24];
        n_s2_west = w_w_prod[32:19];
    end

    logic        r_s2_valid;
    logic [15:0] r_s2_mjd;
    logic [19:0] r_s2_ny;
    logic [16:0] r_s2_nw;
    logic [7:0]  r_s2_yest;
    logic [13:0] r_s2_west;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_mjd  <= r_s1_mjd;
        r_s2_ny   <= r_s1_ny;
        r_s2_nw   <= r_s1_nw;
        r_s2_yest <= n_s2_yest;
        r_s2_west <= n_s2_west;
    end

    // stage 3: one-step correction of both quotients, weekday from the remainder
    logic [20:0] w_ry;
    logic [16:0] w_rw;
    logic [2:0]  w_wd_rem;
    logic [7:0]  n_s3_y;
    logic [2:0]  n_s3_wd;

    always_comb begin
        w_ry     = {1'b0, r_s2_ny} - ({13'b0, r_s2_yest} * YEAR_DIV);
        n_s3_y   = r_s2_yest + {7'b0, (w_ry >= YEAR_DIV)};
        w_rw     = r_s2_nw - ({3'b0, r_s2_west} * WEEK_DIV);
        w_wd_rem = (w_rw >= WEEK_DIV) ? w_rw[2:0] - WEEK_DIV[2:0] : w_rw[2:0];
        n_s3_wd  = w_wd_rem + 3'd1;
    end

    logic        r_s3_valid;
    logic [15:0] r_s3_mjd;
    logic [7:0]  r_s3_y;
    logic [2:0]  r_s3_wd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
        r_s3_mjd <= r_s2_mjd;
        r_s3_y   <= n_s3_y;
        r_s3_wd  <= n_s3_wd;
    end

    // stage 4: whole days in the elapsed years
    logic [16:0] w_yy_full;
    logic [15:0] n_s4_yy;

    always_comb begin
        w_yy_full = ({9'b0, r_s3_y} * YEAR_DAYS) + {11'b0, r_s3_y[7:2]};
        n_s4_yy   = w_yy_full[15:0];
    end

    logic        r_s4_valid;
    logic [15:0] r_s4_mjd;
    logic [7:0]  r_s4_y;
    logic [2:0]  r_s4_wd;
    logic [15:0] r_s4_yy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else begin
            r_s4_valid <= r_s3_valid;
        end
        r_s4_mjd <= r_s3_mjd;
        r_s4_y   <= r_s3_y;
        r_s4_wd  <= r_s3_wd;
        r_s4_yy  <= n_s4_yy;
    end

    // stage 5: month numerator and low byte of the partial day
    logic [15:0] w_diff;
    logic [19:0] w_v_full;
    logic [12:0] n_s5_v;
    logic [7:0]  n_s5_d8;

    always_comb begin
        w_diff   = r_s4_mjd - r_s4_yy;
        w_v_full = ({4'b0, w_diff} * 20'd10) - MONTH_BIAS;
        n_s5_v   = w_v_full[12:0];
        n_s5_d8  = w_diff[7:0] - DAY_BIAS8;
    end

    logic        r_s5_valid;
    logic [7:0]  r_s5_y;
    logic [2:0]  r_s5_wd;
    logic [12:0] r_s5_v;
    logic [7:0]  r_s5_d8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else begin
            r_s5_valid <= r_s4_valid;
        end
        r_s5_y  <= r_s4_y;
        r_s5_wd <= r_s4_wd;
        r_s5_v  <= n_s5_v;
        r_s5_d8 <= n_s5_d8;
    end

    // stage 6: reciprocal estimate of the month quotient
    logic [36:0] w_m_prod;
    logic [3:0]  n_s6_mest;

    always_comb begin
        w_m_prod  = {24'b0, r_s5_v} * {13'b0, MONTH_RECIP};
        n_s6_mest = w_m_prod[35:32];
    end

    logic        r_s6_valid;
    logic [7:0]  r_s6_y;
    logic [2:0]  r_s6_wd;
    logic [12:0] r_s6_v;
    logic [7:0]  r_s6_d8;
    logic [3:0]  r_s6_mest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_valid <= 1'b0;
        end else begin
            r_s6_valid <= r_s5_valid;
        end
        r_s6_y    <= r_s5_y;
        r_s6_wd   <= r_s5_wd;
        r_s6_v    <= r_s5_v;
        r_s6_d8   <= r_s5_d8;
        r_s6_mest <= n_s6_mest;
    end

    // stage 7: one-step correction of the month quotient
    logic [23:0] w_v1000;
    logic [23:0] w_rm;
    logic [3:0]  n_s7_m;

    always_comb begin
        w_v1000 = {11'b0, r_s6_v} * MONTH_SCALE;
        w_rm    = w_v1000 - ({20'b0, r_s6_mest} * MONTH_DIV);
        n_s7_m  = r_s6_mest + {3'b0, (w_rm >= MONTH_DIV)};
    end

    logic        r_s7_valid;
    logic [7:0]  r_s7_y;
    logic [2:0]  r_s7_wd;
    logic [7:0]  r_s7_d8;
    logic [3:0]  r_s7_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_valid <= 1'b0;
        end else begin
            r_s7_valid <= r_s6_valid;
        end
        r_s7_y  <= r_s6_y;
        r_s7_wd <= r_s6_wd;
        r_s7_d8 <= r_s6_d8;
        r_s7_m  <= n_s7_m;
    end

    // stage 8: january/february year carry, month and day clamps
    logic        w_k;
    logic [7:0]  w_mo8;
    logic [8:0]  w_doff;
    logic [7:0]  w_day8;
    t_date       n_date;

    always_comb begin
        w_k          = (r_s7_m == 4'd14) || (r_s7_m == 4'd15);
        w_doff       = month_day_offset(r_s7_m);
        w_mo8        = {4'b0, r_s7_m} - 8'd1 - (w_k ? 8'd12 : 8'd0);
        w_day8       = r_s7_d8 - w_doff[7:0];
        n_date.year  = {3'b0, r_s7_y} + YEAR_BASE + {10'b0, w_k};
        n_date.month = (w_mo8 > 8'd12) ? 4'd1 : w_mo8[3:0];
        n_date.day   = (w_day8 > 8'd31) ? 5'd1 : w_day8[4:0];
        n_date.weekday = r_s7_wd;
    end

    logic  r_out_valid;
    t_date r_out_date;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s7_valid;
        end
        r_out_date <= n_date;
    end

    assign o_valid = r_out_valid;
    assign o_date  = r_out_date;

    // year estimate is never more than one short
    a_year_est : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> (w_ry < (YEAR_DIV + YEAR_DIV)))
        else $error("year quotient estimate off by more than one");

    // week estimate is never more than one short
    a_week_est : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> (w_rw < (WEEK_DIV + WEEK_DIV)))
        else $error("week quotient estimate off by more than one");

    // month estimate is never more than one short
    a_month_est : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s6_valid |-> (w_rm < (MONTH_DIV + MONTH_DIV)))
        else $error("month quotient estimate off by more than one");

    // the formula always lands in march through february
    a_month_span : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s7_valid |-> (r_s7_m >= 4'd4))
        else $error("month quotient below four");

endmodule

@@ sv/mjd_bcd_to_calendar_time.sv @@
// top level: broadcast mjd + bcd time stamp to calendar date and binary time
// depends on mjdc_pkg and mjdc_date
//
//  channel   | handshake           | fields
//  ----------+---------------------+--------------------------------------------
//  stamp in  | start / busy        | i_mjd, i_hour_bcd, i_minute_bcd, i_second_bcd
//  result    | o_valid (strobe)    | o_year, o_month_num, o_day_of_month,
//            |                     | o_weekday, o_hour_bin, o_minute_bin,
//            |                     | o_second_bin
//
// one beat accepted per cycle while busy is low; each result comes out of the date pipeline
// (numerator stages, two reciprocal multiply/correct pairs, the year-length
// stage and the clamp stage) after its beat. busy is high only while reset is held.
// synchronous reset clears all valid bits; payload registers are not reset.
// results are strobed for one cycle and cannot be held off.
module mjd_bcd_to_calendar_time import mjdc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_mjd,
    input  logic [7:0]  i_hour_bcd,
    input  logic [7:0]  i_minute_bcd,
    input  logic [7:0]  i_second_bcd,
    output logic        o_valid,
    output logic [10:0] o_year,
    output logic [3:0]  o_month_num,
    output logic [4:0]  o_day_of_month,
    output logic [2:0]  o_weekday,
    output logic [7:0]  o_hour_bin,
    output logic [7:0]  o_minute_bin,
    output logic [7:0]  o_second_bin
);

    typedef struct packed {
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] second;
    } t_hms;

    // tens * 10 + units, digits unchecked
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
        logic [7:0] tens;
        tens = {4'b0, b[7:4]};
        return (tens << 3) + (tens << 1) + {4'b0, b[3:0]};
    endfunction

    logic  w_accept;
    t_hms  n_hms;

    assign busy     = !i_rst_n;
    assign w_accept = start && !busy;

    always_comb begin
        n_hms.hour   = bcd_to_bin(i_hour_bcd);
        n_hms.minute = bcd_to_bin(i_minute_bcd);
        n_hms.second = bcd_to_bin(i_second_bcd);
    end

    // date pipeline
    logic  w_date_valid;
    t_date w_date;

    mjdc_date u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_mjd   (i_mjd),
        .o_valid (w_date_valid),
        .o_date  (w_date)
    );

    // time of day rides a delay line matched to the date pipeline
    t_hms r_hms_pipe [DATE_LAT];

    always_ff @(posedge i_clk) begin
        r_hms_pipe[0] <= n_hms;
        for (int i = 1; i < DATE_LAT; i++) begin
            r_hms_pipe[i] <= r_hms_pipe[i-1];
        end
    end

    // result beat
    assign o_valid        = w_date_valid;
    assign o_year         = w_date.year;
    assign o_month_num    = w_date.month;
    assign o_day_of_month = w_date.day;
    assign o_weekday      = w_date.weekday;
    assign o_hour_bin     = r_hms_pipe[DATE_LAT-1].hour;
    assign o_minute_bin   = r_hms_pipe[DATE_LAT-1].minute;
    assign o_second_bin   = r_hms_pipe[DATE_LAT-1].second;

endmodule

@@ tb/tb_mjd_bcd_to_calendar_time.sv @@
// self-checking testbench for mjd_bcd_to_calendar_time: directed and random time stamps
// depends on mjdc_pkg and the mjd_bcd_to_calendar_time rtl; a scoreboard class predicts results
`timescale 1ns / 100ps

module tb_mjd_bcd_to_calendar_time;
    import mjdc_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_BEATS = 850;

    // one converted time stamp as seen on the result ports
    typedef struct packed {
        t_date      date;
        logic [7:0] hour_bin;
        logic [7:0] minute_bin;
        logic [7:0] second_bin;
    } t_cal_time;

    // predicts each converted stamp and checks results against them in order
    class calendar_scoreboard;
        t_cal_time   pending_q[$];
        int unsigned stamps_noted;
        int unsigned results_checked;
        int unsigned fail_count;
        int unsigned early_dates;
        int unsigned clamped_dates;

        function new();
            stamps_noted    = 0;
            results_checked = 0;
            fail_count      = 0;
            early_dates     = 0;
            clamped_dates   = 0;
        endfunction

        // tens * 10 + units, no digit check
        function logic [7:0] bcd_to_bin(logic [7:0] b);
            bit [31:0] v;
            v = {28'd0, b[7:4]} * 32'd10 + {28'd0, b[3:0]};
            return v[7:0];
        endfunction

        // integer mjd formula, unsigned 32-bit wraparound throughout
        function t_cal_time convert_stamp(logic [15:0] mjd_in, logic [7:0] h,
                                          logic [7:0] m, logic [7:0] s);
            t_cal_time r;
            bit [31:0] mjd;
            bit [31:0] yr;
            bit [31:0] ylen;
            bit [31:0] mon;
            bit [31:0] dd;
            bit [31:0] k;
            bit [31:0] year_full;
            bit [31:0] mon8;
            bit [31:0] day8;
            bit [31:0] wd;
            bit        clamped;
            mjd = {16'd0, mjd_in};
            clamped = 1'b0;
            // too-early dates fall back to 2005-01-01
            if (mjd <= {16'd0, MJD_FLOOR}) begin
                mjd = {16'd0, MJD_DEFAULT};
                early_dates++;
            end
            yr   = (32'd20 * mjd - 32'd301564) / 32'd7305;
            ylen = yr * 32'd365 + yr / 32'd4;
            mon  = (32'd1000 * (32'd10 * mjd - 32'd149561 - 32'd10 * ylen)) / 32'd306001;
            dd   = mjd - 32'd14956 - ylen - (mon * 32'd306001) / 32'd10000;
            k    = (mon == 32'd14 || mon == 32'd15) ? 32'd1 : 32'd0;
            year_full = yr + k + 32'd1900;
            mon8 = (mon - 32'd1 - k * 32'd12) & 32'hff;
            if (mon8 > 32'd12) begin
                mon8 = 32'd1;
                clamped = 1'b1;
            end
            day8 = dd & 32'hff;
            if (day8 > 32'd31) begin
                day8 = 32'd1;
                clamped = 1'b1;
            end
            if (clamped) clamped_dates++;
            wd = (mjd + 32'd2) % 32'd7 + 32'd1;
            r.date.year    = year_full[10:0];
            r.date.month   = mon8[3:0];
            r.date.day     = day8[4:0];
            r.date.weekday = wd[2:0];
            r.hour_bin     = bcd_to_bin(h);
            r.minute_bin   = bcd_to_bin(m);
            r.second_bin   = bcd_to_bin(s);
            return r;
        endfunction

        // accepted input beat
        function void note_stamp(logic [15:0] mjd_in, logic [7:0] h,
                                 logic [7:0] m, logic [7:0] s);
            pending_q.push_back(convert_stamp(mjd_in, h, m, s));
            stamps_noted++;
        endfunction

        // result strobe, compared field by field with the oldest prediction
        function void check_result(t_cal_time act);
            t_cal_time exp_r;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result beat %p", $time, act);
                fail_count++;
                return;
            end
            exp_r = pending_q.pop_front();
            results_checked++;
            if (act.date.year !== exp_r.date.year) begin
                $display("%0t: year expected %0d actual %0d", $time,
                         exp_r.date.year, act.date.year);
                fail_count++;
            end
            if (act.date.month !== exp_r.date.month) begin
                $display("%0t: month expected %0d actual %0d", $time,
                         exp_r.date.month, act.date.month);
                fail_count++;
            end
            if (act.date.day !== exp_r.date.day) begin
                $display("%0t: day expected %0d actual %0d", $time,
                         exp_r.date.day, act.date.day);
                fail_count++;
            end
            if (act.date.weekday !== exp_r.date.weekday) begin
                $display("%0t: weekday expected %0d actual %0d", $time,
                         exp_r.date.weekday, act.date.weekday);
                fail_count++;
            end
            if (act.hour_bin !== exp_r.hour_bin) begin
                $display("%0t: hour expected %0d actual %0d", $time,
                         exp_r.hour_bin, act.hour_bin);
                fail_count++;
            end
            if (act.minute_bin !== exp_r.minute_bin) begin
                $display("%0t: minute expected %0d actual %0d", $time,
                         exp_r.minute_bin, act.minute_bin);
                fail_count++;
            end
            if (act.second_bin !== exp_r.second_bin) begin
                $display("%0t: second expected %0d actual %0d", $time,
                         exp_r.second_bin, act.second_bin);
                fail_count++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [15:0] i_mjd;
    logic [7:0]  i_hour_bcd;
    logic [7:0]  i_minute_bcd;
    logic [7:0]  i_second_bcd;
    logic        o_valid;
    logic [10:0] o_year;
    logic [3:0]  o_month_num;
    logic [4:0]  o_day_of_month;
    logic [2:0]  o_weekday;
    logic [7:0]  o_hour_bin;
    logic [7:0]  o_minute_bin;
    logic [7:0]  o_second_bin;

    calendar_scoreboard sb;
    int unsigned        cycle_count;

    mjd_bcd_to_calendar_time dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mjd          (i_mjd),
        .i_hour_bcd     (i_hour_bcd),
        .i_minute_bcd   (i_minute_bcd),
        .i_second_bcd   (i_second_bcd),
        .o_valid        (o_valid),
        .o_year         (o_year),
        .o_month_num    (o_month_num),
        .o_day_of_month (o_day_of_month),
        .o_weekday      (o_weekday),
        .o_hour_bin     (o_hour_bin),
        .o_minute_bin   (o_minute_bin),
        .o_second_bin   (o_second_bin)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, sb.pending_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // monitor: accepted input beats and result strobes, sampled at the edge
    always @(posedge i_clk) begin
        t_cal_time act;
        if (o_valid === 1'b1) begin
            act.date.year    = o_year;
            act.date.month   = o_month_num;
            act.date.day     = o_day_of_month;
            act.date.weekday = o_weekday;
            act.hour_bin     = o_hour_bin;
            act.minute_bin   = o_minute_bin;
            act.second_bin   = o_second_bin;
            sb.check_result(act);
        end
        if (start === 1'b1 && busy === 1'b0)
            sb.note_stamp(i_mjd, i_hour_bcd, i_minute_bcd, i_second_bcd);
    end

    // one input beat; optional idle cycles before it, start stays high afterwards
    task automatic send_stamp(input logic [15:0] mjd_v, input logic [7:0] h,
                              input logic [7:0] m, input logic [7:0] s,
                              input int unsigned idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_mjd        <= mjd_v;
        i_hour_bcd   <= h;
        i_minute_bcd <= m;
        i_second_bcd <= s;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    // date mix: early dates, the floor edge, the broadcast era, the top end, anything
    function automatic logic [15:0] pick_mjd();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 10) return 16'($urandom_range(15078));
        if (sel < 20) return 16'($urandom_range(15090, 15066));
        if (sel < 65) return 16'($urandom_range(62000, 40000));
        if (sel < 70) return 16'($urandom_range(65535, 65500));
        return 16'($urandom);
    endfunction

    // mostly well-formed bcd below the limit, sometimes any byte
    function automatic logic [7:0] pick_bcd(int unsigned limit);
        int unsigned v;
        if ($urandom_range(99) < 25) return 8'($urandom);
        v = $urandom_range(limit - 1);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    initial begin
        int unsigned phase_idle[4];
        int unsigned burst_left;
        int unsigned idle_pct;
        sb = new();
        phase_idle[0] = 0;
        phase_idle[1] = 51;
        phase_idle[2] = 0;
        phase_idle[3] = 31;
        burst_left    = 0;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_mjd        <= '0;
        i_hour_bcd   <= '0;
        i_minute_bcd <= '0;
        i_second_bcd <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, floor edge, leap years, january/february
        send_stamp(16'd0,     8'h00, 8'h00, 8'h00, 0);
        send_stamp(16'd15078, 8'hff, 8'hff, 8'hff, 0);
        send_stamp(16'd15079, 8'h23, 8'h59, 8'h59, 0);
        send_stamp(16'd15080, 8'h99, 8'h99, 8'h99, 0);
        send_stamp(16'd15081, 8'ha5, 8'h5a, 8'hf0, 0);
        send_stamp(16'd65535, 8'h0f, 8'hf0, 8'h12, 0);
        send_stamp(16'd65534, 8'h12, 8'h34, 8'h56, 0);
        send_stamp(16'd53371, 8'h00, 8'h00, 8'h00, 0);
        send_stamp(16'd51544, 8'h01, 8'h02, 8'h03, 0);
        send_stamp(16'd51603, 8'h10, 8'h20, 8'h30, 0);
        send_stamp(16'd51604, 8'h11, 8'h22, 8'h33, 0);
        send_stamp(16'd51543, 8'h23, 8'h59, 8'h60, 0);
        send_stamp(16'd50082, 8'h07, 8'h45, 8'h00, 0);
        send_stamp(16'd58849, 8'h05, 8'h05, 8'h05, 0);
        send_stamp(16'd58848, 8'h55, 8'haa, 8'h77, 0);
        send_stamp(16'd54000, 8'hee, 8'hdd, 8'hcc, 0);
        send_stamp(16'd32768, 8'h80, 8'h08, 8'h88, 0);
        send_stamp(16'd15077, 8'h40, 8'h04, 8'h44, 0);
        send_stamp(16'd1,     8'h19, 8'h91, 8'h09, 0);
        send_stamp(16'd60000, 8'h00, 8'h01, 8'h02, 0);

        // random phases with changing sender gaps and gap-free bursts
        for (int unsigned n = 0; n < RANDOM_BEATS; n++) begin
            if (burst_left == 0 && $urandom_range(15) == 0)
                burst_left = $urandom_range(12, 4);
            if (burst_left > 0) begin
                idle_pct = 0;
                burst_left--;
            end else begin
                idle_pct = phase_idle[(n * 4) / RANDOM_BEATS];
            end
            send_stamp(pick_mjd(), pick_bcd(24), pick_bcd(60), pick_bcd(61), idle_pct);
        end
        start <= 1'b0;

        // drain the pipeline, then allow a few stray strobes to show up
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DATE_LAT * 2 + 4) @(posedge i_clk);

        $display("covered %0d stamps, %0d results checked, %0d early dates replaced,",
                 sb.stamps_noted, sb.results_checked, sb.early_dates);
        $display("%0d month/day clamps, sender gaps of 0, 31 and 51 percent",
                 sb.clamped_dates);
        if (sb.fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
